@@ src/base64_stream_encoder_defines.svh @@
// Assertion helpers for the Base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define B64_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define B64_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ src/b64_pkg.sv @@
`timescale 1ns / 1ps

package b64_pkg;

  localparam int QDepth = 2;
  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } slot_t;

  // One accepted byte turns into one job of one to four characters.
  typedef struct packed {
    logic             fin;
    logic [1:0]       last_idx;
    slot_t [3:0]      slot;
  } job_t;

  typedef struct packed {
    logic [$clog2(QDepth+1)-1:0] count;
    logic                        full;
    logic                        empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

@@ src/b64_front.sv @@
`timescale 1ns / 1ps

module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       push,
  output job_t       job,
  output phase_t     phase
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] pend_r, pend_nxt;
  slot_t      pad_slot;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign phase     = phase_r;
  assign pad_slot  = '{pad: 1'b1, sextet: 6'd0};

  always_comb begin
    job       = '0;
    job.fin   = in_tlast;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    case (phase_r)
      PH1: begin
        job.slot[0].sextet = {pend_r[1:0], in_tdata[7:4]};
        if (in_tlast) begin
          job.slot[1].sextet = {in_tdata[3:0], 2'b00};
          job.slot[2]        = pad_slot;
          job.last_idx       = 2'd2;
          phase_nxt          = PH0;
          pend_nxt           = 4'd0;
        end else begin
          job.last_idx = 2'd0;
          phase_nxt    = PH2;
          pend_nxt     = in_tdata[3:0];
        end
      end
      PH2: begin
        job.slot[0].sextet = {pend_r, in_tdata[7:6]};
        job.slot[1].sextet = in_tdata[5:0];
        job.last_idx       = 2'd1;
        phase_nxt          = PH0;
        pend_nxt           = 4'd0;
      end
      default: begin
        job.slot[0].sextet = in_tdata[7:2];
        if (in_tlast) begin
          job.slot[1].sextet = {in_tdata[1:0], 4'b0000};
          job.slot[2]        = pad_slot;
          job.slot[3]        = pad_slot;
          job.last_idx       = 2'd3;
          phase_nxt          = PH0;
          pend_nxt           = 4'd0;
        end else begin
          job.last_idx = 2'd0;
          phase_nxt    = PH1;
          pend_nxt     = {2'b00, in_tdata[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      pend_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

@@ src/b64_queue.sv @@
`timescale 1ns / 1ps

module b64_queue import b64_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    rd_job,
  output q_stat_t stat
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  job_t            mem_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  assign rd_job     = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == CntW'(QDepth));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/b64_back.sv @@
`timescale 1ns / 1ps

module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       load;
  logic       at_end;
  slot_t      cur;

  assign cur    = job.slot[idx_r];
  assign at_end = (idx_r == job.last_idx);
  // The output register refills from a queued job if empty or drained.
  assign load   = !q_empty && (!valid_r || out_tready);
  assign pop    = load && at_end;

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur.pad ? PadChar : b64_char(cur.sextet);
      last_r <= job.fin && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ src/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
// Base64 stream encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per item on in_tdata, in_tlast marks the last
// byte of a message. Output channel: one ASCII character per item on
// out_tdata, out_tlast marks the last character of the encoded message.
// A front stage tracks the position within each three-byte group, turns the
// byte into a job of one to four characters and writes it to a two-entry
// job queue. A back stage drains the queue one character per cycle into a
// registered output, which holds while out_tready is low.
// An accepted byte is written into the job queue; its first character is then
// loaded into the output register once that register is free. Throughput:
// one character per cycle at the output while out_tready is high; a byte
// gives one to four characters (4/3 on average in a long message), and the
// output register is the limit. Bytes are taken while the job queue has room.
// Reset (rst_n low at a clock edge) empties the queue and the output register
// and starts a new group. When the receiver stalls, the output holds, the
// queue fills, and in_tready drops once both entries are taken.
`include "base64_stream_encoder_defines.svh"
module base64_stream_encoder import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_code
  output logic       out_tlast   // end_of_text
);

  logic    push;
  logic    pop;
  job_t    wr_job;
  job_t    rd_job;
  q_stat_t q_stat;
  phase_t  phase;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_stat.full),
    .push      (push),
    .job       (wr_job),
    .phase     (phase)
  );

  b64_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (rd_job),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `B64_ASSERT_NEXT(a_final_restarts_group, push && in_tlast, phase == PH0, "group not restarted")
  `B64_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full, "job written into a full queue")
  `B64_ASSERT_NOW(a_count_in_range, 1'b1, q_stat.count <= 2'(QDepth), "queue count out of range")
  `B64_ASSERT_NOW(a_pop_needs_job, pop, !q_stat.empty, "job taken from an empty queue")

endmodule
